/* hdl/parent_key_value_table_defines.svh */
// Assertion macros for the key/value table RTL, used by the request sequencer.
`ifndef PARENT_KEY_VALUE_TABLE_DEFINES_SVH
`define PARENT_KEY_VALUE_TABLE_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define PKVT_CLK_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);

// Concurrent assertion on the block clock clk and reset rst_n.
`define PKVT_ASSERT(lbl, prop, msg) \
  `PKVT_CLK_ASSERT(lbl, clk, rst_n, prop, msg)

`endif

/* hdl/pkvt_pkg.sv */
// Types and constants shared by the key/value table modules.
package pkvt_pkg;

  localparam int PKVT_DEPTH_DEF = 16;
  localparam int KEY_W   = 32;
  localparam int NODE_W  = 15;
  localparam int SLOT_W  = 4;
  localparam int REQ_W   = 3;
  localparam int STAT_W  = 3;
  localparam int CNT_W   = 5;
  localparam int ENTRY_W = KEY_W + NODE_W;

  localparam logic [REQ_W-1:0] REQ_ASSIGN   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_UNASSIGN = 3'd1;
  localparam logic [REQ_W-1:0] REQ_LOOKUP   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_READ     = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR    = 3'd4;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_PRESENT = 3'd1,
    STAT_ZERO    = 3'd2,
    STAT_FULL    = 3'd3,
    STAT_ABSENT  = 3'd4,
    STAT_RANGE   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_SHIFT,
    FSM_RDSLOT
  } fsm_t;

  typedef struct packed {
    status_t             status;
    logic                found;
    logic [NODE_W-1:0]   node;
    logic [KEY_W-1:0]    key;
    logic [CNT_W-1:0]    count;
  } pkvt_res_t;

endpackage

/* hdl/pkvt_mem.sv */
// Entry store: one write port and one registered read port.
module pkvt_mem import pkvt_pkg::*; #(
  parameter int DEPTH = PKVT_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [ENTRY_W-1:0] wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output logic [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/pkvt_ctrl.sv */
// Request sequencer: key scan, order-preserving compaction and fill count.
`include "parent_key_value_table_defines.svh"

module pkvt_ctrl import pkvt_pkg::*; #(
  parameter int DEPTH = PKVT_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [REQ_W-1:0]   in_req,
  input  logic [KEY_W-1:0]   in_key,
  input  logic [NODE_W-1:0]  in_node,
  input  logic [SLOT_W-1:0]  in_slot,
  input  logic               out_free,
  output logic               res_valid,
  output pkvt_res_t          res,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output logic [ENTRY_W-1:0] mem_wdata,
  output logic               mem_re,
  output logic [AW-1:0]      mem_raddr,
  input  logic [ENTRY_W-1:0] mem_rdata
);

  fsm_t              state_r, state_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [CW-1:0]     addr_r, addr_nxt;
  logic              dv_r, dv_nxt;
  logic [AW-1:0]     daddr_r, daddr_nxt;
  logic [REQ_W-1:0]  req_r, req_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [NODE_W-1:0] node_r, node_nxt;

  logic              accept;
  logic              fill_empty;
  logic              slot_ok;
  logic              is_scan_req;
  logic              start_scan;
  logic [KEY_W-1:0]  rd_key;
  logic [NODE_W-1:0] rd_node;
  logic              d_last;
  logic              hit, miss, shift_last;
  logic              issue;
  logic [CW-1:0]     daddr_ext;

  assign in_ready    = (state_r == FSM_IDLE) && out_free;
  assign accept      = in_valid && in_ready;
  assign fill_empty  = (fill_r == '0);
  assign slot_ok     = (CW + SLOT_W)'(in_slot) < (CW + SLOT_W)'(fill_r);
  assign is_scan_req = ((in_req == REQ_ASSIGN) || (in_req == REQ_UNASSIGN)
                        || (in_req == REQ_LOOKUP)) && (in_key != '0);
  assign start_scan  = accept && is_scan_req && !fill_empty;

  assign rd_key     = mem_rdata[ENTRY_W-1:NODE_W];
  assign rd_node    = mem_rdata[NODE_W-1:0];
  assign daddr_ext  = CW'(daddr_r);
  assign d_last     = dv_r && ((daddr_ext + CW'(1)) == fill_r);
  assign hit        = (state_r == FSM_SCAN) && dv_r && (rd_key == key_r);
  assign miss       = (state_r == FSM_SCAN) && d_last && (rd_key != key_r);
  assign shift_last = (state_r == FSM_SHIFT) && d_last;
  assign issue      = ((state_r == FSM_SCAN) || (state_r == FSM_SHIFT))
                      && (addr_r != fill_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: begin
        if (start_scan) begin
          state_nxt = FSM_SCAN;
        end else if (accept && (in_req == REQ_READ) && slot_ok) begin
          state_nxt = FSM_RDSLOT;
        end
      end
      FSM_SCAN: begin
        if (hit) begin
          if ((req_r == REQ_UNASSIGN) && !d_last) begin
            state_nxt = FSM_SHIFT;
          end else begin
            state_nxt = FSM_IDLE;
          end
        end else if (miss) begin
          state_nxt = FSM_IDLE;
        end
      end
      FSM_SHIFT: begin
        if (shift_last) begin
          state_nxt = FSM_IDLE;
        end
      end
      FSM_RDSLOT: begin
        state_nxt = FSM_IDLE;
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  // Datapath, memory control and result.
  always_comb begin
    fill_nxt   = fill_r;
    addr_nxt   = addr_r;
    dv_nxt     = 1'b0;
    daddr_nxt  = daddr_r;
    req_nxt    = req_r;
    key_nxt    = key_r;
    node_nxt   = node_r;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = {key_r, node_r};
    mem_re     = 1'b0;
    mem_raddr  = addr_r[AW-1:0];
    res_valid  = 1'b0;
    res.status = STAT_OK;
    res.found  = 1'b0;
    res.node   = '0;
    res.key    = '0;

    unique case (state_r)
      FSM_IDLE: begin
        if (accept) begin
          req_nxt  = in_req;
          key_nxt  = in_key;
          node_nxt = in_node;
          if (start_scan) begin
            // Entry zero is read now and checked in the first scan cycle.
            mem_re    = 1'b1;
            mem_raddr = '0;
            dv_nxt    = 1'b1;
            daddr_nxt = '0;
            addr_nxt  = CW'(1);
          end else if ((in_req == REQ_READ) && slot_ok) begin
            mem_re    = 1'b1;
            mem_raddr = AW'(in_slot);
          end else begin
            res_valid = 1'b1;
            case (in_req) inside
              REQ_ASSIGN: begin
                if (in_key == '0) begin
                  res.status = STAT_ZERO;
                end else begin
                  // Empty table: the pair goes straight into entry zero.
                  mem_we    = 1'b1;
                  mem_waddr = '0;
                  mem_wdata = {in_key, in_node};
                  fill_nxt  = CW'(1);
                end
              end
              REQ_UNASSIGN, REQ_LOOKUP: res.status = STAT_ABSENT;
              REQ_READ:                 res.status = STAT_RANGE;
              REQ_CLEAR:                fill_nxt   = '0;
              default:                  res.status = STAT_OK;
            endcase
          end
        end
      end
      FSM_SCAN: begin
        if (issue && !hit && !miss) begin
          mem_re    = 1'b1;
          addr_nxt  = addr_r + CW'(1);
          dv_nxt    = 1'b1;
          daddr_nxt = addr_r[AW-1:0];
        end
        if (hit) begin
          res.found = 1'b1;
          res.node  = rd_node;
          node_nxt  = rd_node;
          if (req_r == REQ_ASSIGN) begin
            res.status = STAT_PRESENT;
            res_valid  = 1'b1;
          end else if ((req_r == REQ_UNASSIGN) && !d_last) begin
            // Compaction starts with the entry after the one removed.
            addr_nxt = daddr_ext + CW'(1);
          end else begin
            res_valid = 1'b1;
            if (req_r == REQ_UNASSIGN) begin
              fill_nxt = fill_r - CW'(1);
            end
          end
        end else if (miss) begin
          res_valid = 1'b1;
          if (req_r == REQ_ASSIGN) begin
            if (fill_r >= CW'(DEPTH)) begin
              res.status = STAT_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = fill_r[AW-1:0];
              mem_wdata = {key_r, node_r};
              fill_nxt  = fill_r + CW'(1);
            end
          end else begin
            res.status = STAT_ABSENT;
          end
        end
      end
      FSM_SHIFT: begin
        if (issue) begin
          mem_re    = 1'b1;
          addr_nxt  = addr_r + CW'(1);
          dv_nxt    = 1'b1;
          daddr_nxt = addr_r[AW-1:0];
        end
        if (dv_r) begin
          mem_we    = 1'b1;
          mem_waddr = daddr_r - AW'(1);
          mem_wdata = mem_rdata;
        end
        if (shift_last) begin
          res_valid = 1'b1;
          res.found = 1'b1;
          res.node  = node_r;
          fill_nxt  = fill_r - CW'(1);
        end
      end
      FSM_RDSLOT: begin
        res_valid = 1'b1;
        res.found = 1'b1;
        res.node  = rd_node;
        res.key   = rd_key;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase

    res.count = CNT_W'(fill_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
      fill_r  <= '0;
      dv_r    <= 1'b0;
      addr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      dv_r    <= dv_nxt;
      addr_r  <= addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    daddr_r <= daddr_nxt;
    req_r   <= req_nxt;
    key_r   <= key_nxt;
    node_r  <= node_nxt;
  end

  `PKVT_ASSERT(a_res_has_room, res_valid |-> out_free, "result with output register full")
  `PKVT_ASSERT(a_fill_with_res, !$stable(fill_r) |-> $past(res_valid), "fill changed without result")
  `PKVT_ASSERT(a_no_rw_collide, (mem_we && mem_re) |-> (mem_waddr != mem_raddr), "same entry read and written")

endmodule

/* hdl/parent_key_value_table.sv */
// Top level of the ordered key/value table with its output register.
//
// Usage: requests arrive on the in_ stream, one transaction per request; each
// request gives exactly one result transaction on the out_ stream, in order.
// Assign, unassign and lookup scan the stored keys one entry per cycle through
// the single read port of the entry store. Unassign of an entry that is not the
// last then compacts the table, one entry moved per cycle. Read slot does one
// memory read. Clear, unused codes, zero keys, out-of-range slot reads and
// requests on an empty table answer in the cycle of acceptance, and the result
// is visible in the next cycle.
// One request is in flight at a time; in_tready is high only while the
// sequencer is idle and the output register is empty or being emptied.
// A result waiting in the output register while out_tready is low holds it,
// and no new request is taken until that result leaves.
// Reset (rst_n low at a clock edge) empties the table and drops any pending
// result; entry contents are not cleared, since entries at or above the fill
// count are never read.
module parent_key_value_table import pkvt_pkg::*; #(
  parameter int DEPTH = PKVT_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // key[31:0], local_node[46:32], slot_index[50:47], zero
  input  logic [2:0]  in_tuser,   // req_type[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // node_out[14:0], key_out[46:15], entry_count[51:47], zero
  output logic [3:0]  out_tuser   // status[2:0], found[3]
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic               out_free;
  logic               res_valid;
  pkvt_res_t          res;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;

  logic               out_valid_r, out_valid_nxt;
  pkvt_res_t          out_res_r;

  // The output register may take a new result when it is empty or when its
  // current transaction completes in this cycle.
  assign out_free = !out_valid_r || out_tready;

  pkvt_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_req    (in_tuser),
    .in_key    (in_tdata[31:0]),
    .in_node   (in_tdata[46:32]),
    .in_slot   (in_tdata[50:47]),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  pkvt_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_res_r.count, out_res_r.key, out_res_r.node};
  assign out_tuser  = {out_res_r.found, out_res_r.status};

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the ordered parent key/value table stream block.
module testbench;
  import pkvt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = PKVT_DEPTH_DEF;
  // The run limit leaves several times the length of the longest correct run.
  localparam longint RUN_LIMIT_NS = 64'd8_000_000;
  // Drain time, long enough for a full-table unassign of the first entry to scan and compact.
  localparam int DRAIN_CYCLES = 4 * DEPTH;

  // Mix of request kinds used by one random phase.
  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BALANCED
  } traffic_mix_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;   // key[31:0], local_node[46:32], slot_index[50:47], zero
  logic [2:0]  in_tuser = '0;   // req_type[2:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;       // node_out[14:0], key_out[46:15], entry_count[51:47], zero
  logic [3:0]  out_tuser;       // status[2:0], found[3]

  // Shadow copy of the table contents, updated as each request transaction is accepted.
  logic [KEY_W-1:0]  tbl_keys  [DEPTH];
  logic [NODE_W-1:0] tbl_nodes [DEPTH];
  int                tbl_fill = 0;

  // Results the table owes us, oldest first.
  pkvt_res_t pending_results[$];
  int        mismatch_count = 0;
  int        tx_burst_left = 0;

  // Receiver stall pattern state.
  int rx_mode = 0;
  int rx_mode_left = 0;
  int rx_phase = 0;

  parent_key_value_table #(.DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one request to the shadow table and returns the result it must produce.
  // Entries at or beyond the fill count are never read, matching the block.
  function automatic pkvt_res_t apply_request(logic [REQ_W-1:0] req, logic [KEY_W-1:0] key,
                                              logic [NODE_W-1:0] node, logic [SLOT_W-1:0] slot);
    pkvt_res_t res;
    int        pos;
    res = '0;
    res.status = STAT_OK;
    pos = tbl_fill;
    for (int i = tbl_fill - 1; i >= 0; i--) begin
      if (tbl_keys[i] == key) pos = i;
    end
    case (req)
      REQ_ASSIGN: begin
        if (key == '0) begin
          res.status = STAT_ZERO;
        end else if (pos < tbl_fill) begin
          res.status = STAT_PRESENT;
          res.found  = 1'b1;
          res.node   = tbl_nodes[pos];
        end else if (tbl_fill >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          tbl_keys[tbl_fill]  = key;
          tbl_nodes[tbl_fill] = node;
          tbl_fill++;
        end
      end
      REQ_UNASSIGN: begin
        if (key == '0 || pos >= tbl_fill) begin
          res.status = STAT_ABSENT;
        end else begin
          res.found = 1'b1;
          res.node  = tbl_nodes[pos];
          // Later entries move down one place so insertion order is kept.
          for (int i = pos; i + 1 < tbl_fill; i++) begin
            tbl_keys[i]  = tbl_keys[i + 1];
            tbl_nodes[i] = tbl_nodes[i + 1];
          end
          tbl_fill--;
        end
      end
      REQ_LOOKUP: begin
        if (key == '0 || pos >= tbl_fill) begin
          res.status = STAT_ABSENT;
        end else begin
          res.found = 1'b1;
          res.node  = tbl_nodes[pos];
        end
      end
      REQ_READ: begin
        if (int'(slot) < tbl_fill) begin
          res.found = 1'b1;
          res.node  = tbl_nodes[slot];
          res.key   = tbl_keys[slot];
        end else begin
          res.status = STAT_RANGE;
        end
      end
      REQ_CLEAR: begin
        tbl_fill = 0;
      end
      default: begin
        // Unused request codes do nothing and answer ok.
      end
    endcase
    res.count = tbl_fill[CNT_W-1:0];
    return res;
  endfunction

  // Sends one request transaction. The sender works in bursts; between bursts it
  // usually drops tvalid for a random gap. tvalid is only lowered here or at the
  // very end, so a back-to-back request never sees tvalid toggled within one step.
  task automatic send_request(logic [REQ_W-1:0] req, logic [KEY_W-1:0] key,
                              logic [NODE_W-1:0] node, logic [SLOT_W-1:0] slot);
    if (tx_burst_left == 0) begin
      tx_burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 9) < 7) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {5'b0, slot, node, key};
    do @(posedge clk); while (!in_tready);
    pending_results.insert(pending_results.size(), apply_request(req, key, node, slot));
    tx_burst_left--;
  endtask

  task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
    if (expected !== actual) begin
      mismatch_count++;
      if (mismatch_count <= 100) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, expected, actual);
      end
    end
  endtask

  // Result checker: every result transaction is compared with the oldest expectation.
  always @(posedge clk) begin
    pkvt_res_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $error("result transaction arrived with no request outstanding");
      end else begin
        exp_res = pending_results.pop_front();
        check_field("status", 32'(exp_res.status), 32'(out_tuser[2:0]));
        check_field("found", 32'(exp_res.found), 32'(out_tuser[3]));
        check_field("node_out", 32'(exp_res.node), 32'(out_tdata[14:0]));
        check_field("key_out", exp_res.key, out_tdata[46:15]);
        check_field("entry_count", 32'(exp_res.count), 32'(out_tdata[51:47]));
      end
    end
  end

  // Receiver backpressure. The pattern switches at random intervals between
  // always ready, alternating, coin-flip and long stalls.
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      <= $urandom_range(0, 3);
      rx_mode_left <= $urandom_range(20, 200);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    rx_phase <= rx_phase + 1;
    case (rx_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= rx_phase[0];
      2:       out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= ((rx_phase % 32) >= 22);
    endcase
  end

  // Empty table: lookup, read and unassign miss; an assign with a zero key is refused.
  task automatic test_empty_table();
    send_request(REQ_CLEAR, 32'h0000_0000, 15'h0000, 4'h0);
    send_request(REQ_LOOKUP, 32'h0000_0005, 15'h0000, 4'h0);
    send_request(REQ_READ, 32'h0000_0000, 15'h0000, 4'h0);
    send_request(REQ_UNASSIGN, 32'h0000_0007, 15'h0000, 4'h0);
    send_request(REQ_ASSIGN, 32'h0000_0000, 15'h7FFF, 4'hF);
  endtask

  // Extreme key and node values, reads inside and outside the fill count.
  task automatic test_extreme_fields();
    send_request(REQ_ASSIGN, 32'hFFFF_FFFF, 15'h7FFF, 4'h0);
    send_request(REQ_ASSIGN, 32'h0000_0001, 15'h0000, 4'h0);
    send_request(REQ_ASSIGN, 32'h8000_0000, 15'h4000, 4'hF);
    send_request(REQ_READ, 32'h0000_0000, 15'h0000, 4'h0);
    send_request(REQ_READ, 32'hFFFF_FFFF, 15'h7FFF, 4'h2);
    send_request(REQ_READ, 32'h0000_0000, 15'h0000, 4'h3);
    send_request(REQ_READ, 32'h0000_0000, 15'h0000, 4'hF);
    send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 15'h0000, 4'h0);
    send_request(REQ_LOOKUP, 32'h0000_0000, 15'h0000, 4'h0);
  endtask

  // A repeated assign reports the stored node; an unassign from the middle
  // compacts the table; a zero key is never found.
  task automatic test_duplicates_and_removal();
    send_request(REQ_ASSIGN, 32'hFFFF_FFFF, 15'h0123, 4'h0);
    send_request(REQ_UNASSIGN, 32'h0000_0001, 15'h0000, 4'h0);
    send_request(REQ_READ, 32'h0000_0000, 15'h0000, 4'h1);
    send_request(REQ_UNASSIGN, 32'h0000_0000, 15'h0000, 4'h0);
    send_request(REQ_UNASSIGN, 32'hFFFF_FFFF, 15'h0000, 4'h0);
    send_request(REQ_LOOKUP, 32'h0000_0001, 15'h0000, 4'h0);
  endtask

  // Request codes five to seven carry random fields and must change nothing.
  task automatic test_unused_codes();
    for (int code = 5; code <= 7; code++) begin
      send_request(REQ_W'(code), $urandom(), 15'($urandom()), 4'($urandom()));
    end
    send_request(REQ_CLEAR, $urandom(), 15'($urandom()), 4'($urandom()));
  endtask

  // Picks a key that is in the table when there is one, otherwise a random one.
  function automatic logic [KEY_W-1:0] stored_key_or_random();
    if (tbl_fill > 0) return tbl_keys[$urandom_range(0, tbl_fill - 1)];
    return $urandom();
  endfunction

  // One random phase. Keys are mostly ones already stored (or fresh ones for
  // assign), so the table goes deep, fills up and gets compacted often.
  task automatic run_random_phase(traffic_mix_t mix, int n_items);
    int                roll;
    int                keysel;
    logic [REQ_W-1:0]  req;
    logic [KEY_W-1:0]  key;
    logic [NODE_W-1:0] node;
    logic [SLOT_W-1:0] slot;
    for (int n = 0; n < n_items; n++) begin
      roll = $urandom_range(0, 99);
      case (mix)
        MIX_FILL:  req = (roll < 70) ? REQ_ASSIGN : (roll < 78) ? REQ_UNASSIGN :
                         (roll < 88) ? REQ_LOOKUP : (roll < 99) ? REQ_READ : REQ_W'(5);
        MIX_DRAIN: req = (roll < 15) ? REQ_ASSIGN : (roll < 75) ? REQ_UNASSIGN :
                         (roll < 85) ? REQ_LOOKUP : (roll < 98) ? REQ_READ : REQ_CLEAR;
        default:   req = (roll < 35) ? REQ_ASSIGN : (roll < 55) ? REQ_UNASSIGN :
                         (roll < 72) ? REQ_LOOKUP : (roll < 94) ? REQ_READ :
                         (roll < 97) ? REQ_CLEAR : REQ_W'($urandom_range(5, 7));
      endcase
      keysel = $urandom_range(0, 99);
      if (keysel < 5) begin
        key = '0;
      end else if (req == REQ_ASSIGN) begin
        key = (keysel < 20) ? stored_key_or_random() : $urandom();
      end else begin
        key = (keysel < 70) ? stored_key_or_random() : $urandom();
      end
      node = 15'($urandom_range(0, 32767));
      if (tbl_fill > 0 && $urandom_range(0, 3) != 0) begin
        slot = SLOT_W'($urandom_range(0, tbl_fill - 1));
      end else begin
        slot = SLOT_W'($urandom_range(0, 15));
      end
      send_request(req, key, node, slot);
    end
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 10; phase++) begin
      run_random_phase(traffic_mix_t'(phase % 3), 123);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_extreme_fields();
    test_duplicates_and_removal();
    test_unused_codes();
    test_random_traffic();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    #(RUN_LIMIT_NS * 1ns);
    $display("== FAIL ==");
    $finish;
  end

endmodule
